>>> hdl/mba_pkg.sv
`timescale 1ns / 1ps

package mba_pkg;

    // Field widths of the sample and result transactions.
    localparam int CH_W      = 4;
    localparam int SAMPLE_W  = 12;
    localparam int SUM_W     = 20;
    localparam int COUNT_W   = 9;
    localparam int SCAN_W    = 8;
    localparam int REM_W     = 9;

    // Default configuration and parameter values.
    localparam int CHANNELS_DEF  = 10;
    localparam logic [COUNT_W-1:0] AVG_COUNT_RESET = 9'd16;
    localparam logic [COUNT_W-1:0] AVG_COUNT_MAX   = 9'd256;
    localparam logic [SAMPLE_W-1:0] AVERAGE_MAX    = 12'd4095;

    // Divider steps: one quotient bit per cycle.
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Queue between the front and back ends.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // One division job handed from the front to the back.
    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] divisor;
        logic               last;
    } t_job;

endpackage

>>> hdl/mba_in_if.sv
`timescale 1ns / 1ps

interface mba_in_if import mba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

>>> hdl/mba_out_if.sv
`timescale 1ns / 1ps

interface mba_out_if import mba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CH_W-1:0]     out_channel;
    logic [SAMPLE_W-1:0] average;
    logic                update_done;

    modport source (output valid, output out_channel, output average, output update_done,
                    input ready);
    modport sink   (input valid, input out_channel, input average, input update_done,
                    output ready);
endinterface

>>> hdl/mba_front.sv
`timescale 1ns / 1ps

module mba_front import mba_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mba_in_if.sink             i_in,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata,
    input  logic               i_full,
    output logic               o_push,
    output t_job               o_job
);

    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_EXT_W = (IDX_W > CH_W) ? IDX_W : CH_W;

    logic [COUNT_W-1:0] r_average_count;
    logic [SUM_W-1:0]   r_sums [CHANNELS];
    logic [SCAN_W-1:0]  r_scan_count;

    logic [COUNT_W-1:0] eff_count;
    logic [SCAN_W-1:0]  final_idx;
    logic [CH_EXT_W-1:0] ch_ext;
    logic [IDX_W-1:0]   idx;
    logic               in_range;
    logic               last_ch;
    logic               final_scan;
    logic               accept;
    logic [SUM_W-1:0]   sum_new;

    // The front takes a sample whenever the job queue has room.
    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    // Clamp the configured count into 1..256.
    always_comb begin
        if (r_average_count == '0) begin
            eff_count = COUNT_W'(1);
        end else if (r_average_count > AVG_COUNT_MAX) begin
            eff_count = AVG_COUNT_MAX;
        end else begin
            eff_count = r_average_count;
        end
    end
    assign final_idx = SCAN_W'(eff_count - COUNT_W'(1));

    // Classify the incoming sample.
    assign ch_ext     = CH_EXT_W'(i_in.channel);
    assign idx        = ch_ext[IDX_W-1:0];
    assign in_range   = (32'(ch_ext) < 32'(CHANNELS));
    assign last_ch    = (32'(ch_ext) == 32'(CHANNELS - 1));
    assign final_scan = (r_scan_count >= final_idx);
    assign sum_new    = r_sums[idx] + SUM_W'(i_in.sample);

    // A sample of the final scan becomes a division job.
    assign o_push        = accept && in_range && final_scan;
    assign o_job.channel = i_in.channel;
    assign o_job.sum     = sum_new;
    assign o_job.divisor = eff_count;
    assign o_job.last    = last_ch;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_average_count <= AVG_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_average_count <= i_cfg_wdata;
        end
    end

    // Running sums and scan counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_sums[i] <= '0;
            end
            r_scan_count <= '0;
        end else if (accept && in_range) begin
            r_sums[idx] <= final_scan ? '0 : sum_new;
            if (last_ch) begin
                r_scan_count <= final_scan ? '0 : r_scan_count + SCAN_W'(1);
            end
        end
    end

endmodule

>>> hdl/mba_queue.sv
`timescale 1ns / 1ps

module mba_queue import mba_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hdl/mba_back.sv
`timescale 1ns / 1ps

module mba_back import mba_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  t_job i_job,
    output logic o_pop,
    mba_out_if.source o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [STEP_W-1:0]  r_step;
    logic [SUM_W-1:0]   r_quo;
    logic [REM_W-1:0]   r_rem;
    logic [COUNT_W-1:0] r_divisor;
    logic [CH_W-1:0]    r_channel;
    logic               r_last;

    logic               r_out_valid;
    logic [CH_W-1:0]    r_out_channel;
    logic [SAMPLE_W-1:0] r_out_average;
    logic               r_out_done;

    logic [REM_W:0]     rem_sh;
    logic               q_bit;
    logic [REM_W:0]     rem_diff;
    logic               out_free;
    logic [SAMPLE_W-1:0] avg_sat;

    // One restoring division step per cycle.
    assign rem_sh   = {r_rem, r_quo[SUM_W-1]};
    assign q_bit    = (rem_sh >= (REM_W+1)'(r_divisor));
    assign rem_diff = rem_sh - (REM_W+1)'(r_divisor);

    // Saturate the quotient to the sample range.
    assign avg_sat  = (r_quo > SUM_W'(AVERAGE_MAX)) ? AVERAGE_MAX : r_quo[SAMPLE_W-1:0];

    assign out_free = !r_out_valid || o_out.ready;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    assign o_out.valid       = r_out_valid;
    assign o_out.out_channel = r_out_channel;
    assign o_out.average     = r_out_average;
    assign o_out.update_done = r_out_done;

    // Divider sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            // The result leaves here unless a new one is loaded in the same cycle.
            if (r_out_valid && o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_quo     <= i_job.sum;
                        r_rem     <= '0;
                        r_divisor <= i_job.divisor;
                        r_channel <= i_job.channel;
                        r_last    <= i_job.last;
                        r_step    <= '0;
                        r_state   <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= q_bit ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
                    r_quo  <= {r_quo[SUM_W-2:0], q_bit};
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_channel <= r_channel;
                        r_out_average <= avg_sat;
                        r_out_done    <= r_last;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> hdl/multichannel_block_averager.sv
`timescale 1ns / 1ps

// Multichannel boxcar averager: samples tagged with a channel number are summed per channel
// over average_count scans, and during the final scan each channel's sum is divided by the
// count, emitted as one result transaction and cleared. The front end takes one sample
// transaction per cycle while its two-entry job queue has room; samples outside the final
// scan produce no result. Each averaged sample goes through a shared restoring divider
// of 20 steps that yields one quotient bit per cycle and takes no new job until its last
// result has been loaded into the output register, so that divider sets the sustained
// rate of the final scan.
module multichannel_block_averager import mba_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mba_in_if.sink             i_in,
    mba_out_if.source          o_out,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata
);

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    t_job job_in;
    t_job job_out;

    // Sample intake, running sums and scan tracking.
    mba_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_job       (job_in)
    );

    // Job queue between intake and divider.
    mba_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (job_out),
        .o_empty (q_empty)
    );

    // Divider and result register.
    mba_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_job   (job_out),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule
